@@ sv/asep_pkg.sv @@
// ----------------------------------------------------------------------------
// asep_pkg: shared types and constants of the ANSI SGR escape parser
// Byte codes, SGR codes, attribute record, event codes and sizing.
// ----------------------------------------------------------------------------
package asep_pkg;

  localparam int MAX_PARAM_CHARS = 33;
  localparam int MAX_FIELDS      = 8;

  localparam int COUNT_W     = $clog2(MAX_PARAM_CHARS + 1);
  localparam int FIELD_IDX_W = $clog2(MAX_FIELDS + 1);
  localparam int FIELD_SEL_W = $clog2(MAX_FIELDS);

  localparam logic [3:0] COLOR_DEFAULT = 4'd8;

  // Attribute flag bit positions
  localparam int FLAG_BOLD      = 0;
  localparam int FLAG_UNDERLINE = 1;
  localparam int FLAG_OVERLINE  = 2;
  localparam int FLAG_STRIKE    = 3;
  localparam int FLAG_INVERSE   = 4;
  localparam int FLAG_BLINK     = 5;

  // Byte codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_SGR   = 8'h6D;  // m
  localparam logic [7:0] CH_CLEAR = 8'h4A;  // J
  localparam logic [7:0] CH_BELL  = 8'h47;  // G
  localparam logic [7:0] CH_CUU   = 8'h41;  // A
  localparam logic [7:0] CH_CUD   = 8'h42;  // B
  localparam logic [7:0] CH_CUF   = 8'h43;  // C
  localparam logic [7:0] CH_CUB   = 8'h44;  // D
  localparam logic [7:0] CH_SCP   = 8'h73;  // s
  localparam logic [7:0] CH_RCP   = 8'h75;  // u
  localparam logic [7:0] CH_CUP   = 8'h48;  // H
  localparam logic [7:0] CH_EL    = 8'h4B;  // K
  localparam logic [7:0] CH_DL    = 8'h4D;  // M
  localparam logic [7:0] CH_RM    = 8'h6C;  // l
  localparam logic [7:0] CH_SM    = 8'h68;  // h

  // SGR codes
  localparam logic [7:0] SGR_RESET      = 8'd0;
  localparam logic [7:0] SGR_BOLD       = 8'd1;
  localparam logic [7:0] SGR_UNDER_ON   = 8'd4;
  localparam logic [7:0] SGR_UNDER_OFF  = 8'd24;
  localparam logic [7:0] SGR_OVER_ON    = 8'd53;
  localparam logic [7:0] SGR_OVER_OFF   = 8'd55;
  localparam logic [7:0] SGR_STRIKE_ON  = 8'd9;
  localparam logic [7:0] SGR_STRIKE_OFF = 8'd29;
  localparam logic [7:0] SGR_INV_ON     = 8'd7;
  localparam logic [7:0] SGR_INV_OFF    = 8'd27;
  localparam logic [7:0] SGR_BLINK_ON   = 8'd5;
  localparam logic [7:0] SGR_BLINK_OFF  = 8'd25;
  localparam logic [7:0] SGR_FG_LO      = 8'd30;
  localparam logic [7:0] SGR_FG_HI      = 8'd37;
  localparam logic [7:0] SGR_BG_LO      = 8'd40;
  localparam logic [7:0] SGR_BG_HI      = 8'd47;

  localparam logic [7:0] PARAM_SAT = 8'd255;

  typedef enum logic [1:0] {
    PM_GROUND = 2'd0,
    PM_ESC    = 2'd1,
    PM_SEQ    = 2'd2
  } parse_mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_BELL  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    EV_DROP,
    EV_ESC,
    EV_CHAR,
    EV_OPEN,
    EV_ERROR,
    EV_SGR,
    EV_CLEAR,
    EV_BELL,
    EV_CURSOR,
    EV_PARAM
  } event_t;

  typedef struct packed {
    logic [5:0] flags;
    logic [3:0] fg;
    logic [3:0] bg;
  } attr_t;

  localparam attr_t ATTR_RESET = '{flags: 6'd0, fg: COLOR_DEFAULT, bg: COLOR_DEFAULT};

  typedef logic [MAX_FIELDS-1:0][7:0] param_vals_t;

  typedef struct packed {
    logic start;
    logic take;
  } param_ctl_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic       attr_start;
    attr_t      attr;
  } result_t;

endpackage

@@ sv/asep_if.sv @@
// ----------------------------------------------------------------------------
// asep_if: handshake channels of the ANSI SGR escape parser
// Byte channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface asep_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface asep_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic       attr_start;
  logic       bold;
  logic       underline;
  logic       overline;
  logic       strike;
  logic       inverse;
  logic       blink;
  logic [3:0] fg_color;
  logic [3:0] bg_color;

  modport source (output valid, output kind, output out_char, output attr_start,
                  output bold, output underline, output overline, output strike,
                  output inverse, output blink, output fg_color, output bg_color,
                  input ready);
  modport sink   (input valid, input kind, input out_char, input attr_start,
                  input bold, input underline, input overline, input strike,
                  input inverse, input blink, input fg_color, input bg_color,
                  output ready);
endinterface

@@ sv/ansi_sgr_escape_parser_top.sv @@
// ----------------------------------------------------------------------------
// ansi_sgr_escape_parser_top: ANSI CSI / SGR escape parser
// Turns a terminal byte stream into attributed characters and screen events.
// ----------------------------------------------------------------------------
// Usage:
//   text   - byte channel (valid/ready): in_byte and chunk_end, the latter
//            marking the last byte of a received chunk.
//   result - result channel (valid/ready): kind, out_char, attr_start and the
//            current attributes. Bytes that open or carry an escape sequence,
//            and bytes dropped after a sequence error, give no transaction.
//   A byte is taken into an input register, handled from there by the
//   classifier, the field accumulator and the SGR walk, and its result (if
//   any) lands in the output register as the byte advances.
//   One byte per cycle is sustained while the receiver keeps ready high; the
//   rate is set by the single input-register-to-result-register pass.
//   When the receiver stalls, the held result stays put, the input register
//   still takes one more byte, and then text.ready drops until the result is
//   taken. Synchronous reset empties both registers, returns the parser to
//   ground state and sets default colours with all flags clear.
// ----------------------------------------------------------------------------
module ansi_sgr_escape_parser_top (
  input logic          clk,
  input logic          rst,
  asep_text_if.sink    text,
  asep_result_if.source result
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       go;

  // parser state
  asep_pkg::parse_mode_t mode, mode_next;
  asep_pkg::attr_t       attr, attr_next;
  logic                  pending, pending_next;
  logic                  discarding, discarding_next;

  // datapath
  asep_pkg::event_t                 evt;
  asep_pkg::param_ctl_t             pctl;
  asep_pkg::param_vals_t            vals;
  logic [asep_pkg::FIELD_IDX_W-1:0] field_index;
  logic                             seq_full;
  asep_pkg::attr_t                  sgr_attr;

  // result register
  logic              res_valid;
  asep_pkg::result_t res;
  logic              out_valid;
  asep_pkg::result_t out_res;

  // advance the held byte when the result register is free or being emptied
  assign go         = s1_valid && (!out_valid || result.ready);
  assign text.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.in_byte;
      s1_last <= text.chunk_end;
    end
  end

  asep_classify u_classify (
    .mode       (mode),
    .discarding (discarding),
    .seq_full   (seq_full),
    .in_byte    (s1_byte),
    .evt        (evt)
  );

  assign pctl.start = go && (evt == asep_pkg::EV_OPEN);
  assign pctl.take  = go && (evt == asep_pkg::EV_PARAM);

  asep_param_acc u_param_acc (
    .clk         (clk),
    .rst         (rst),
    .ctl         (pctl),
    .in_byte     (s1_byte),
    .vals        (vals),
    .field_index (field_index),
    .seq_full    (seq_full)
  );

  asep_sgr_apply u_sgr_apply (
    .vals        (vals),
    .field_index (field_index),
    .attr_in     (attr),
    .attr_out    (sgr_attr)
  );

  // next-state logic
  always_comb begin
    mode_next       = mode;
    attr_next       = attr;
    pending_next    = pending;
    discarding_next = discarding;
    unique case (evt)
      asep_pkg::EV_DROP: begin
        // leave discard mode on the byte that ends the chunk
        if (s1_last) begin
          discarding_next = 1'b0;
        end
      end
      asep_pkg::EV_ESC:  mode_next = asep_pkg::PM_ESC;
      asep_pkg::EV_CHAR: pending_next = 1'b0;
      asep_pkg::EV_OPEN: mode_next = asep_pkg::PM_SEQ;
      asep_pkg::EV_ERROR: begin
        mode_next       = asep_pkg::PM_GROUND;
        attr_next       = asep_pkg::ATTR_RESET;
        pending_next    = 1'b0;
        discarding_next = !s1_last;
      end
      asep_pkg::EV_SGR: begin
        mode_next    = asep_pkg::PM_GROUND;
        attr_next    = sgr_attr;
        pending_next = 1'b1;
      end
      asep_pkg::EV_CLEAR: begin
        mode_next    = asep_pkg::PM_GROUND;
        attr_next    = asep_pkg::ATTR_RESET;
        pending_next = 1'b0;
      end
      asep_pkg::EV_BELL:   mode_next = asep_pkg::PM_GROUND;
      asep_pkg::EV_CURSOR: mode_next = asep_pkg::PM_GROUND;
      asep_pkg::EV_PARAM:  mode_next = mode;
      default:             mode_next = mode;
    endcase
  end

  // result logic
  always_comb begin
    res_valid      = 1'b0;
    res.kind       = asep_pkg::KIND_CHAR;
    res.out_char   = 8'd0;
    res.attr_start = 1'b0;
    res.attr       = attr;
    unique case (evt)
      asep_pkg::EV_CHAR: begin
        res_valid      = 1'b1;
        res.out_char   = s1_byte;
        res.attr_start = pending;
      end
      asep_pkg::EV_ERROR: begin
        res_valid = 1'b1;
        res.kind  = asep_pkg::KIND_ERROR;
        res.attr  = asep_pkg::ATTR_RESET;
      end
      asep_pkg::EV_CLEAR: begin
        res_valid = 1'b1;
        res.kind  = asep_pkg::KIND_CLEAR;
        res.attr  = asep_pkg::ATTR_RESET;
      end
      asep_pkg::EV_BELL: begin
        res_valid = 1'b1;
        res.kind  = asep_pkg::KIND_BELL;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= asep_pkg::PM_GROUND;
      attr       <= asep_pkg::ATTR_RESET;
      pending    <= 1'b0;
      discarding <= 1'b0;
    end else if (go) begin
      mode       <= mode_next;
      attr       <= attr_next;
      pending    <= pending_next;
      discarding <= discarding_next;
    end
  end

  // result register: load on advance, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= res_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      out_res <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_res.kind;
  assign result.out_char   = out_res.out_char;
  assign result.attr_start = out_res.attr_start;
  assign result.bold       = out_res.attr.flags[asep_pkg::FLAG_BOLD];
  assign result.underline  = out_res.attr.flags[asep_pkg::FLAG_UNDERLINE];
  assign result.overline   = out_res.attr.flags[asep_pkg::FLAG_OVERLINE];
  assign result.strike     = out_res.attr.flags[asep_pkg::FLAG_STRIKE];
  assign result.inverse    = out_res.attr.flags[asep_pkg::FLAG_INVERSE];
  assign result.blink      = out_res.attr.flags[asep_pkg::FLAG_BLINK];
  assign result.fg_color   = out_res.attr.fg;
  assign result.bg_color   = out_res.attr.bg;

endmodule

@@ sv/asep_classify.sv @@
// ----------------------------------------------------------------------------
// asep_classify: byte classifier
// Maps the held byte and parser mode to the event it causes.
// ----------------------------------------------------------------------------
module asep_classify (
  input  asep_pkg::parse_mode_t mode,
  input  logic                  discarding,
  input  logic                  seq_full,
  input  logic [7:0]            in_byte,
  output asep_pkg::event_t      evt
);

  logic is_param;
  logic is_cursor;

  assign is_param = ((in_byte >= asep_pkg::CH_0) && (in_byte <= asep_pkg::CH_9))
                    || (in_byte == asep_pkg::CH_SEMI) || (in_byte == asep_pkg::CH_QUERY);

  assign is_cursor = (in_byte == asep_pkg::CH_CUU) || (in_byte == asep_pkg::CH_CUD)
                     || (in_byte == asep_pkg::CH_CUF) || (in_byte == asep_pkg::CH_CUB)
                     || (in_byte == asep_pkg::CH_SCP) || (in_byte == asep_pkg::CH_RCP)
                     || (in_byte == asep_pkg::CH_CUP) || (in_byte == asep_pkg::CH_EL)
                     || (in_byte == asep_pkg::CH_DL) || (in_byte == asep_pkg::CH_RM)
                     || (in_byte == asep_pkg::CH_SM);

  always_comb begin
    evt = asep_pkg::EV_ERROR;
    priority if (discarding) begin
      evt = asep_pkg::EV_DROP;
    end else if (mode == asep_pkg::PM_GROUND) begin
      evt = (in_byte == asep_pkg::CH_ESC) ? asep_pkg::EV_ESC : asep_pkg::EV_CHAR;
    end else if (mode == asep_pkg::PM_ESC) begin
      evt = (in_byte == asep_pkg::CH_LBRKT) ? asep_pkg::EV_OPEN : asep_pkg::EV_ERROR;
    end else if (seq_full) begin
      evt = asep_pkg::EV_ERROR;
    end else if (in_byte == asep_pkg::CH_SGR) begin
      evt = asep_pkg::EV_SGR;
    end else if (in_byte == asep_pkg::CH_CLEAR) begin
      evt = asep_pkg::EV_CLEAR;
    end else if (in_byte == asep_pkg::CH_BELL) begin
      evt = asep_pkg::EV_BELL;
    end else if (is_cursor) begin
      evt = asep_pkg::EV_CURSOR;
    end else if (is_param) begin
      evt = asep_pkg::EV_PARAM;
    end else begin
      evt = asep_pkg::EV_ERROR;
    end
  end

endmodule

@@ sv/asep_param_acc.sv @@
// ----------------------------------------------------------------------------
// asep_param_acc: parameter field accumulator
// Builds decimal field values as digits arrive; counts parameter characters.
// ----------------------------------------------------------------------------
module asep_param_acc (
  input  logic                                    clk,
  input  logic                                    rst,
  input  asep_pkg::param_ctl_t                    ctl,
  input  logic [7:0]                              in_byte,
  output asep_pkg::param_vals_t                   vals,
  output logic [asep_pkg::FIELD_IDX_W-1:0]        field_index,
  output logic                                    seq_full
);

  logic [asep_pkg::COUNT_W-1:0]     count;
  logic                             stopped;
  logic [asep_pkg::FIELD_IDX_W-1:0] fi_inc;
  logic                             in_range;
  logic                             inc_in_range;
  logic [7:0]                       cur;
  logic [11:0]                      acc;
  logic [7:0]                       sat;
  logic                             is_semi;
  logic                             is_query;

  assign is_semi      = (in_byte == asep_pkg::CH_SEMI);
  assign is_query     = (in_byte == asep_pkg::CH_QUERY);
  assign fi_inc       = field_index + asep_pkg::FIELD_IDX_W'(1);
  assign in_range     = field_index < asep_pkg::FIELD_IDX_W'(asep_pkg::MAX_FIELDS);
  assign inc_in_range = fi_inc < asep_pkg::FIELD_IDX_W'(asep_pkg::MAX_FIELDS);
  assign cur          = vals[field_index[asep_pkg::FIELD_SEL_W-1:0]];
  // value * 10 + digit; a decimal digit's code has the digit in its low nibble
  assign acc          = ({4'd0, cur} << 3) + ({4'd0, cur} << 1) + {8'd0, in_byte[3:0]};
  assign sat          = (acc > 12'(asep_pkg::PARAM_SAT)) ? asep_pkg::PARAM_SAT : acc[7:0];
  assign seq_full     = count >= asep_pkg::COUNT_W'(asep_pkg::MAX_PARAM_CHARS);

  // field storage: each field is zeroed as it opens
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      vals[0] <= 8'd0;
    end else if (ctl.take) begin
      if (is_semi) begin
        if (in_range && inc_in_range) begin
          vals[fi_inc[asep_pkg::FIELD_SEL_W-1:0]] <= 8'd0;
        end
      end else if (!is_query && !stopped && in_range) begin
        vals[field_index[asep_pkg::FIELD_SEL_W-1:0]] <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      field_index <= '0;
      stopped     <= 1'b0;
    end else if (ctl.start) begin
      count       <= '0;
      field_index <= '0;
      stopped     <= 1'b0;
    end else if (ctl.take) begin
      count <= count + asep_pkg::COUNT_W'(1);
      if (is_semi) begin
        if (in_range) begin
          field_index <= fi_inc;
        end
        stopped <= 1'b0;
      end else if (is_query) begin
        stopped <= 1'b1;
      end
    end
  end

endmodule

@@ sv/asep_sgr_apply.sv @@
// ----------------------------------------------------------------------------
// asep_sgr_apply: SGR field walk
// Applies the collected fields in order to the current attributes.
// ----------------------------------------------------------------------------
module asep_sgr_apply (
  input  asep_pkg::param_vals_t             vals,
  input  logic [asep_pkg::FIELD_IDX_W-1:0]  field_index,
  input  asep_pkg::attr_t                   attr_in,
  output asep_pkg::attr_t                   attr_out
);

  logic [7:0] v;
  logic       stop;

  always_comb begin
    attr_out = attr_in;
    stop     = 1'b0;
    v        = 8'd0;
    for (int i = 0; i < asep_pkg::MAX_FIELDS; i++) begin
      v = vals[i];
      if (!stop && (asep_pkg::FIELD_IDX_W'(i) <= field_index)) begin
        unique case (v)
          asep_pkg::SGR_RESET: begin
            // reset all and end the walk
            attr_out = asep_pkg::ATTR_RESET;
            stop     = 1'b1;
          end
          asep_pkg::SGR_BOLD:       attr_out.flags[asep_pkg::FLAG_BOLD]      = 1'b1;
          asep_pkg::SGR_UNDER_ON:   attr_out.flags[asep_pkg::FLAG_UNDERLINE] = 1'b1;
          asep_pkg::SGR_UNDER_OFF:  attr_out.flags[asep_pkg::FLAG_UNDERLINE] = 1'b0;
          asep_pkg::SGR_OVER_ON:    attr_out.flags[asep_pkg::FLAG_OVERLINE]  = 1'b1;
          asep_pkg::SGR_OVER_OFF:   attr_out.flags[asep_pkg::FLAG_OVERLINE]  = 1'b0;
          asep_pkg::SGR_STRIKE_ON:  attr_out.flags[asep_pkg::FLAG_STRIKE]    = 1'b1;
          asep_pkg::SGR_STRIKE_OFF: attr_out.flags[asep_pkg::FLAG_STRIKE]    = 1'b0;
          asep_pkg::SGR_INV_ON:     attr_out.flags[asep_pkg::FLAG_INVERSE]   = 1'b1;
          asep_pkg::SGR_INV_OFF:    attr_out.flags[asep_pkg::FLAG_INVERSE]   = 1'b0;
          asep_pkg::SGR_BLINK_ON:   attr_out.flags[asep_pkg::FLAG_BLINK]     = 1'b1;
          asep_pkg::SGR_BLINK_OFF:  attr_out.flags[asep_pkg::FLAG_BLINK]     = 1'b0;
          default: begin
            if ((v >= asep_pkg::SGR_FG_LO) && (v <= asep_pkg::SGR_FG_HI)) begin
              attr_out.fg = 4'(v - asep_pkg::SGR_FG_LO);
            end else if ((v >= asep_pkg::SGR_BG_LO) && (v <= asep_pkg::SGR_BG_HI)) begin
              attr_out.bg = 4'(v - asep_pkg::SGR_BG_LO);
            end
          end
        endcase
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ANSI SGR escape parser
// Feeds terminal byte chunks through the byte channel, predicts every
// attributed character and screen event, and checks them in order on the
// result channel under bursty input and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import asep_pkg::*;

  // Receiver behaviour per phase
  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  localparam logic [7:0] CURSOR_FINALS [0:10] = '{
    CH_CUU, CH_CUD, CH_CUF, CH_CUB, CH_SCP, CH_RCP, CH_CUP, CH_EL, CH_DL, CH_RM, CH_SM
  };
  localparam logic [7:0] FLAG_CODES [0:10] = '{
    SGR_BOLD, SGR_UNDER_ON, SGR_UNDER_OFF, SGR_OVER_ON, SGR_OVER_OFF, SGR_STRIKE_ON,
    SGR_STRIKE_OFF, SGR_INV_ON, SGR_INV_OFF, SGR_BLINK_ON, SGR_BLINK_OFF
  };
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst;

  asep_text_if   byte_ch ();
  asep_result_if res_ch ();

  ansi_sgr_escape_parser_top u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (byte_ch),
    .result (res_ch)
  );

  // --------------------------------------------------------------------------
  // Clock and reset: 4 ns period, reset held at the start and never again.
  // Every input of the block is given a known value at time zero.
  // --------------------------------------------------------------------------
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.in_byte   = 8'h00;
    byte_ch.chunk_end = 1'b0;
    res_ch.ready      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser predictor: a private copy of the parse state, advanced once per
  // accepted byte transaction.
  // --------------------------------------------------------------------------
  parse_mode_t mode         = PM_GROUND;
  logic        span_pending = 1'b0;
  attr_t       cur_attr     = ATTR_RESET;
  int          char_count   = 0;
  int          field_at     = 0;
  logic [7:0]  field_val [MAX_FIELDS] = '{default: 8'h00};
  logic        dropping     = 1'b0;
  logic        digits_held  = 1'b0;

  result_t     char_events_q [$];  // attributed characters and events still owed

  function automatic void clear_all();
    mode         = PM_GROUND;
    span_pending = 1'b0;
    cur_attr     = ATTR_RESET;
    char_count   = 0;
    field_at     = 0;
    digits_held  = 1'b0;
  endfunction

  function automatic result_t make_event(kind_t k, logic [7:0] ch, logic st);
    result_t r;
    r.kind       = k;
    r.out_char   = ch;
    r.attr_start = st;
    r.attr       = cur_attr;
    return r;
  endfunction

  function automatic result_t seq_error(logic last);
    clear_all();
    dropping = !last;
    return make_event(KIND_ERROR, 8'h00, 1'b0);
  endfunction

  function automatic bit is_cursor(logic [7:0] b);
    foreach (CURSOR_FINALS[i])
      if (b == CURSOR_FINALS[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_param(logic [7:0] b);
    return (b >= CH_0 && b <= CH_9) || b == CH_SEMI || b == CH_QUERY;
  endfunction

  // Walk the collected fields; a zero field wipes everything and ends the walk
  function automatic void apply_sgr();
    int n;
    n = (field_at + 1 > MAX_FIELDS) ? MAX_FIELDS : field_at + 1;
    for (int i = 0; i < n; i++) begin
      case (field_val[i])
        SGR_RESET: begin
          clear_all();
          return;
        end
        SGR_BOLD:       cur_attr.flags[FLAG_BOLD]      = 1'b1;
        SGR_UNDER_ON:   cur_attr.flags[FLAG_UNDERLINE] = 1'b1;
        SGR_UNDER_OFF:  cur_attr.flags[FLAG_UNDERLINE] = 1'b0;
        SGR_OVER_ON:    cur_attr.flags[FLAG_OVERLINE]  = 1'b1;
        SGR_OVER_OFF:   cur_attr.flags[FLAG_OVERLINE]  = 1'b0;
        SGR_STRIKE_ON:  cur_attr.flags[FLAG_STRIKE]    = 1'b1;
        SGR_STRIKE_OFF: cur_attr.flags[FLAG_STRIKE]    = 1'b0;
        SGR_INV_ON:     cur_attr.flags[FLAG_INVERSE]   = 1'b1;
        SGR_INV_OFF:    cur_attr.flags[FLAG_INVERSE]   = 1'b0;
        SGR_BLINK_ON:   cur_attr.flags[FLAG_BLINK]     = 1'b1;
        SGR_BLINK_OFF:  cur_attr.flags[FLAG_BLINK]     = 1'b0;
        default: begin
          if (field_val[i] >= SGR_FG_LO && field_val[i] <= SGR_FG_HI)
            cur_attr.fg = 4'(field_val[i] - SGR_FG_LO);
          else if (field_val[i] >= SGR_BG_LO && field_val[i] <= SGR_BG_HI)
            cur_attr.bg = 4'(field_val[i] - SGR_BG_LO);
        end
      endcase
    end
  endfunction

  function automatic void take_param(logic [7:0] b);
    int v;
    char_count++;
    if (b == CH_SEMI) begin
      if (field_at < MAX_FIELDS) field_at++;
      if (field_at < MAX_FIELDS) field_val[field_at] = 8'h00;
      digits_held = 1'b0;
    end else if (b == CH_QUERY) begin
      digits_held = 1'b1;
    end else if (!digits_held && field_at < MAX_FIELDS) begin
      v = int'(field_val[field_at]) * 10 + int'(b - CH_0);
      field_val[field_at] = (v > 255) ? PARAM_SAT : 8'(v);
    end
  endfunction

  // Advance the parse state by one byte; returns 1 when a result is owed
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    logic st;
    r = '0;
    if (dropping) begin
      if (last) dropping = 1'b0;
      return 1'b0;
    end
    case (mode)
      PM_GROUND: begin
        if (b == CH_ESC) begin
          mode = PM_ESC;
          return 1'b0;
        end
        st           = span_pending;
        span_pending = 1'b0;
        r            = make_event(KIND_CHAR, b, st);
        return 1'b1;
      end
      PM_ESC: begin
        if (b != CH_LBRKT) begin
          r = seq_error(last);
          return 1'b1;
        end
        mode         = PM_SEQ;
        char_count   = 0;
        field_at     = 0;
        digits_held  = 1'b0;
        field_val[0] = 8'h00;
        return 1'b0;
      end
      default: begin
        if (char_count >= MAX_PARAM_CHARS) begin
          r = seq_error(last);
          return 1'b1;
        end
        if (b == CH_SGR) begin
          mode = PM_GROUND;
          apply_sgr();
          span_pending = 1'b1;
          return 1'b0;
        end
        if (b == CH_CLEAR) begin
          clear_all();
          r = make_event(KIND_CLEAR, 8'h00, 1'b0);
          return 1'b1;
        end
        if (b == CH_BELL) begin
          mode = PM_GROUND;
          r    = make_event(KIND_BELL, 8'h00, 1'b0);
          return 1'b1;
        end
        if (is_cursor(b)) begin
          mode = PM_GROUND;
          return 1'b0;
        end
        if (is_param(b)) begin
          take_param(b);
          return 1'b0;
        end
        r = seq_error(last);
        return 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders: bytes go into the pending queue that the driver drains.
  // Inside random chunks an early chunk end is sprinkled in at mark_rate.
  // --------------------------------------------------------------------------
  text_item_t pending_bytes_q [$];
  int         items_made = 0;
  int         mark_rate  = 0;

  task automatic put(logic [7:0] b);
    text_item_t it;
    it.b    = b;
    it.last = (mark_rate > 0) && ($urandom_range(1, mark_rate) == 1);
    pending_bytes_q.push_back(it);
    items_made++;
  endtask

  task automatic end_chunk();
    pending_bytes_q[pending_bytes_q.size() - 1].last = 1'b1;
  endtask

  task automatic put_num(int v);
    if (v >= 100) put(CH_0 + 8'(v / 100));
    if (v >= 10)  put(CH_0 + 8'((v / 10) % 10));
    put(CH_0 + 8'(v % 10));
  endtask

  task automatic put_param_char();
    int r;
    r = $urandom_range(0, 11);
    if (r < 10)       put(CH_0 + 8'(r));
    else if (r == 10) put(CH_SEMI);
    else              put(CH_QUERY);
  endtask

  task automatic put_field();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0: ;                                        // empty field reads as zero
      1: put_num(0);
      2, 3, 4, 5, 6: put_num(int'(FLAG_CODES[$urandom_range(0, 10)]));
      7: put_num(int'(SGR_FG_LO) + $urandom_range(0, 7));
      8: put_num(int'(SGR_BG_LO) + $urandom_range(0, 7));
      9: put_num($urandom_range(0, 255));
      10: repeat ($urandom_range(3, 5)) put(CH_0 + 8'($urandom_range(0, 9)));
      default: begin
        // a query mark freezes the digits of its field
        if ($urandom_range(0, 1)) put_num(int'(FLAG_CODES[$urandom_range(0, 10)]));
        put(CH_QUERY);
        repeat ($urandom_range(0, 2)) put(CH_0 + 8'($urandom_range(0, 9)));
      end
    endcase
  endtask

  task automatic put_fields(int nf);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) put(CH_SEMI);
      put_field();
    end
  endtask

  task automatic put_token();
    int         w;
    logic [7:0] b;
    w = $urandom_range(0, 99);
    if (w < 35) begin
      repeat ($urandom_range(1, 6)) begin
        b = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                        : 8'($urandom_range(0, 255));
        if (b == CH_ESC) b = 8'($urandom_range(8'h20, 8'h7E));
        put(b);
      end
    end else if (w < 60) begin
      put(CH_ESC);
      put(CH_LBRKT);
      put_fields(($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(6, 11));
      put(CH_SGR);
    end else if (w < 76) begin
      // clear, bell or a cursor final, sometimes with one or two fields ahead of it
      put(CH_ESC);
      put(CH_LBRKT);
      if ($urandom_range(0, 1)) put_fields($urandom_range(1, 2));
      if (w < 65)      put(CH_CLEAR);
      else if (w < 70) put(CH_BELL);
      else             put(CURSOR_FINALS[$urandom_range(0, 10)]);
    end else if (w < 80) begin
      // fill the parameter store to the brim and beyond
      put(CH_ESC);
      put(CH_LBRKT);
      repeat ($urandom_range(MAX_PARAM_CHARS - 1, MAX_PARAM_CHARS + 2)) put_param_char();
      case ($urandom_range(0, 3))
        0: put(CH_SGR);
        1: put(CH_CLEAR);
        2: put(CH_BELL);
        default: put_param_char();
      endcase
    end else if (w < 86) begin
      put(CH_ESC);
      do b = 8'($urandom_range(0, 255)); while (b == CH_LBRKT);
      put(b);
    end else if (w < 92) begin
      put(CH_ESC);
      put(CH_LBRKT);
      repeat ($urandom_range(0, 4)) put_param_char();
      do b = 8'($urandom_range(0, 255));
      while (is_param(b) || is_cursor(b) || b == CH_SGR || b == CH_CLEAR || b == CH_BELL);
      put(b);
    end else begin
      put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_stream(int n);
    int target;
    target    = items_made + n;
    mark_rate = 20;
    while (items_made < target) begin
      repeat ($urandom_range(1, 6)) put_token();
      end_chunk();
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: bursts of random length with random gaps while send_gaps is set;
  // predict on every accepted byte transaction. valid only moves when the slot is free.
  // --------------------------------------------------------------------------
  bit         send_gaps  = 1'b1;
  int         burst_left = 0;
  int         gap_left   = 0;
  text_item_t drv_item;
  result_t    drv_event;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.in_byte   <= 8'h00;
      byte_ch.chunk_end <= 1'b0;
      burst_left         = 0;
      gap_left           = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (parse_byte(byte_ch.in_byte, byte_ch.chunk_end, drv_event))
          char_events_q.push_back(drv_event);
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gaps && gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (pending_bytes_q.size() > 0) begin
          drv_item           = pending_bytes_q.pop_front();
          byte_ch.valid     <= 1'b1;
          byte_ch.in_byte   <= drv_item.b;
          byte_ch.chunk_end <= drv_item.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 3);
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall style per phase, plus a long hold-off counted here on
  // request so the block fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  rx_style_t   rx_style     = RX_RANDOM;
  int          hold_request = 0;
  int          hold_served  = 0;
  int          hold_left    = 0;
  logic [15:0] stall_pat    = 16'b1101_0011_1110_0101;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            stall_pat     = {stall_pat[14:0], stall_pat[15]};
            res_ch.ready <= stall_pat[0];
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare every accepted result transaction with the oldest
  // owed event. Report the first ten failures in full, count the rest.
  // --------------------------------------------------------------------------
  int      err_count = 0;
  result_t mon_exp;
  result_t mon_act;

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      mon_act.kind       = kind_t'(res_ch.kind);
      mon_act.out_char   = res_ch.out_char;
      mon_act.attr_start = res_ch.attr_start;
      mon_act.attr.flags = {res_ch.blink, res_ch.inverse, res_ch.strike,
                            res_ch.overline, res_ch.underline, res_ch.bold};
      mon_act.attr.fg    = res_ch.fg_color;
      mon_act.attr.bg    = res_ch.bg_color;
      if (char_events_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: kind %0d char %02h", res_ch.kind, res_ch.out_char);
      end else begin
        mon_exp = char_events_q.pop_front();
        if (res_ch.kind !== mon_exp.kind || mon_act.out_char !== mon_exp.out_char ||
            mon_act.attr_start !== mon_exp.attr_start ||
            mon_act.attr.flags !== mon_exp.attr.flags ||
            mon_act.attr.fg !== mon_exp.attr.fg || mon_act.attr.bg !== mon_exp.attr.bg) begin
          err_count++;
          // each pair reads expected / actual
          if (err_count <= 10)
            $display(
              "mismatch kind %0d/%0d char %h/%h start %b/%b flags %b/%b fg %0d/%0d bg %0d/%0d",
              mon_exp.kind, res_ch.kind, mon_exp.out_char, mon_act.out_char,
              mon_exp.attr_start, mon_act.attr_start,
              mon_exp.attr.flags, mon_act.attr.flags,
              mon_exp.attr.fg, mon_act.attr.fg, mon_exp.attr.bg, mon_act.attr.bg);
        end
      end
    end
  end

  // Hold the sender until every byte is gone and every owed result has come
  task automatic wait_drained();
    while (pending_bytes_q.size() != 0 || byte_ch.valid || char_events_q.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // Directed: extreme bytes, colour with a frozen field, saturation and an
    // empty field that wipes everything, bell, clear, cursor, both errors.
    send_gaps = 1'b1;
    rx_style  = RX_RANDOM;
    mark_rate = 0;
    put(8'h00);
    put(8'hFF);
    end_chunk();
    put(CH_ESC); put(CH_LBRKT); put_num(31); put(CH_SEMI); put_num(4);
    put(CH_QUERY); put_num(7); put(CH_SGR);
    put(8'h61);                                   // first character of a new span
    put(CH_ESC); put(CH_LBRKT); put_num(999); put(CH_SEMI); put(CH_SEMI);
    put_num(5); put(CH_SGR);
    put(8'h63);
    put(CH_ESC); put(CH_LBRKT); put_num(7); put(CH_BELL);
    put(CH_ESC); put(CH_LBRKT); put(CH_CLEAR);
    put(CH_ESC); put(CH_LBRKT); put(CH_CUP);
    put(CH_ESC); put(8'h58);                      // bad byte after ESC, chunk goes on
    put(8'h71);
    end_chunk();                                  // dropped up to here
    put(CH_ESC); put(CH_LBRKT); put(8'h40);       // bad byte inside the sequence
    end_chunk();
    wait_drained();

    // Random with bursts and random stalls; one long receiver hold-off
    put_stream(350);
    hold_request++;
    put_stream(300);
    wait_drained();

    // Full rate in both directions
    send_gaps = 1'b0;
    rx_style  = RX_OPEN;
    put_stream(250);
    wait_drained();

    // Bursts again against a fixed stall pattern
    send_gaps = 1'b1;
    rx_style  = RX_PATTERN;
    put_stream(250);
    wait_drained();

    // Allow a stray late result to show up
    repeat (20) @(posedge clk);
    if (err_count == 0 && char_events_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
